// File: rtl/rqp_pkg.sv
// shared types and constants of the ready queue picker
`timescale 1ns / 1ps

package rqp_pkg;

    // field widths of one request and one result
    localparam int unsigned ID_W     = 16;
    localparam int unsigned EST_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ORDER_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PROD_W   = TIME_W + EST_W;
    localparam int unsigned ENTRY_W  = ID_W + EST_W + TIME_W + ORDER_W;

    // request kinds
    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // scheduling policies
    localparam logic POLICY_SJF  = 1'b0;
    localparam logic POLICY_HRRN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic idx_inc;
        logic ins_write;
        logic set_full;
        logic cand_load;
        logic mul;
        logic cmp;
        logic finish;
        logic out_load;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic cur_valid;
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/rqp_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module rqp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/rqp_ctrl.sv
// controller state machine of the ready queue picker
`timescale 1ns / 1ps

module rqp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_req_type,
    output logic             o_in_ready,
    output rqp_pkg::t_dp_cmd o_cmd,
    input  rqp_pkg::t_dp_sts i_sts
);

    import rqp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ISCAN  = 8'b0000_0010,
        S_DSCAN  = 8'b0000_0100,
        S_LOAD   = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_CMP    = 8'b0010_0000,
        S_FINISH = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_req_type == REQ_DISPATCH) ? S_DSCAN : S_ISCAN;
                end
            end
            S_ISCAN: begin
                if (!i_sts.cur_valid) begin
                    o_cmd.ins_write = 1'b1;
                    n_state = S_RESULT;
                end else if (i_sts.idx_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DSCAN: begin
                if (i_sts.cur_valid) begin
                    n_state = S_LOAD;
                end else if (i_sts.idx_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.cand_load = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_DSCAN;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/rqp_datapath.sv
// datapath of the ready queue picker: table, scan index, ratio compare, result
`timescale 1ns / 1ps

module rqp_datapath #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rqp_pkg::t_dp_cmd               i_cmd,
    output rqp_pkg::t_dp_sts               o_sts,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic [rqp_pkg::ID_W-1:0]       i_task_id,
    input  logic [rqp_pkg::EST_W-1:0]      i_burst_estimate,
    input  logic [rqp_pkg::TIME_W-1:0]     i_now_time,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rqp_pkg::ID_W-1:0]       o_chosen_id,
    output logic [rqp_pkg::STATUS_W-1:0]   o_status
);

    import rqp_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // request registers
    logic                r_policy;
    logic [ID_W-1:0]     r_id;
    logic [EST_W-1:0]    r_est;
    logic [TIME_W-1:0]   r_now;
    logic [ORDER_W-1:0]  r_seq;

    // table occupancy and scan index
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]       r_idx;

    // candidate and best slot
    logic [ID_W-1:0]     r_cand_task;
    logic [EST_W-1:0]    r_cand_est;
    logic [TIME_W-1:0]   r_cand_wait;
    logic [ORDER_W-1:0]  r_cand_age;
    logic [IDX_W-1:0]    r_cand_idx;
    logic [ID_W-1:0]     r_best_task;
    logic [EST_W-1:0]    r_best_est;
    logic [TIME_W-1:0]   r_best_wait;
    logic [ORDER_W-1:0]  r_best_age;
    logic [IDX_W-1:0]    r_best_idx;
    logic                r_found;
    logic [PROD_W-1:0]   r_lhs;
    logic [PROD_W-1:0]   r_rhs;

    // pending result and output register
    logic [ID_W-1:0]     r_res_id;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_id;
    logic [STATUS_W-1:0] r_out_status;

    // ram signals
    logic [ENTRY_W-1:0]  w_wdata;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [EST_W-1:0]    w_est_fix;
    logic [ID_W-1:0]     w_rd_task;
    logic [EST_W-1:0]    w_rd_est;
    logic [TIME_W-1:0]   w_rd_arr;
    logic [ORDER_W-1:0]  w_rd_order;
    logic                w_beats;

    // slot entry: task, estimate, arrival, insert order from the lowest bit up
    assign w_est_fix = (r_est == '0) ? EST_W'(1) : r_est;
    assign w_wdata   = {r_seq, r_now, w_est_fix, r_id};
    assign w_rd_task  = w_rdata[ID_W-1:0];
    assign w_rd_est   = w_rdata[ID_W +: EST_W];
    assign w_rd_arr   = w_rdata[ID_W+EST_W +: TIME_W];
    assign w_rd_order = w_rdata[ID_W+EST_W+TIME_W +: ORDER_W];

    rqp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_write),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // candidate against best: policy key first, then age
    always_comb begin
        if (r_policy == POLICY_SJF) begin
            if (r_cand_est != r_best_est) begin
                w_beats = (r_cand_est < r_best_est);
            end else begin
                w_beats = (r_cand_age > r_best_age);
            end
        end else begin
            if (r_lhs != r_rhs) begin
                w_beats = (r_lhs > r_rhs);
            end else begin
                w_beats = (r_cand_age > r_best_age);
            end
        end
    end

    // control state: policy, occupancy, sequence, scan index, found flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POLICY_SJF;
            r_valid     <= '0;
            r_seq       <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.ins_write) begin
                r_valid[r_idx] <= 1'b1;
                r_seq          <= r_seq + ORDER_W'(1);
            end
            if (i_cmd.cmp) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish && r_found) begin
                r_valid[r_best_idx] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // request capture
        if (i_cmd.accept) begin
            r_id  <= i_task_id;
            r_est <= i_burst_estimate;
            r_now <= i_now_time;
        end
        // candidate load: wait saturating at zero, and age
        if (i_cmd.cand_load) begin
            r_cand_task <= w_rd_task;
            r_cand_est  <= w_rd_est;
            r_cand_wait <= (r_now < w_rd_arr) ? '0 : (r_now - w_rd_arr);
            r_cand_age  <= r_seq - w_rd_order;
            r_cand_idx  <= r_idx;
        end
        // cross products of the response ratio compare
        if (i_cmd.mul) begin
            r_lhs <= PROD_W'(r_cand_wait) * PROD_W'(r_best_est);
            r_rhs <= PROD_W'(r_best_wait) * PROD_W'(r_cand_est);
        end
        // best update
        if (i_cmd.cmp && (!r_found || w_beats)) begin
            r_best_task <= r_cand_task;
            r_best_est  <= r_cand_est;
            r_best_wait <= r_cand_wait;
            r_best_age  <= r_cand_age;
            r_best_idx  <= r_cand_idx;
        end
        // result of the request
        if (i_cmd.ins_write) begin
            r_res_id     <= r_id;
            r_res_status <= ST_INSERTED;
        end else if (i_cmd.set_full) begin
            r_res_id     <= r_id;
            r_res_status <= ST_FULL;
        end else if (i_cmd.finish) begin
            r_res_id     <= r_found ? r_best_task : '0;
            r_res_status <= r_found ? ST_DISPATCHED : ST_EMPTY;
        end
        if (i_cmd.out_load) begin
            r_out_id     <= r_res_id;
            r_out_status <= r_res_status;
        end
    end

    // status to the controller
    assign o_sts.cur_valid = r_valid[r_idx];
    assign o_sts.idx_last  = (r_idx == IDX_LAST);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_chosen_id = r_out_id;
    assign o_status    = r_out_status;

endmodule

// File: rtl/ready_queue_sjf_hrrn_picker.sv
// ready queue picker, shortest job first or highest response ratio next
// insert: scans the slots from index 0 to the lowest free one and writes it, or reports full
// dispatch: visits every slot, with load, multiply and compare steps per occupied slot; the single
// table ram port and the compare loop over the slots set how long this takes
// one request at a time; the next is taken while the result waits in its register
// reset clears occupancy, insert sequence, policy and handshakes; slot data is not reset
`timescale 1ns / 1ps

module ready_queue_sjf_hrrn_picker #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // policy register
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // task_id[15:0], burst_estimate[31:16], now_time[63:32]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // chosen_id[15:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    import rqp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // controller
    rqp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath
    rqp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_task_id        (s_axis_tdata[ID_W-1:0]),
        .i_burst_estimate (s_axis_tdata[ID_W +: EST_W]),
        .i_now_time       (s_axis_tdata[ID_W+EST_W +: TIME_W]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_chosen_id      (m_axis_tdata),
        .o_status         (m_axis_tuser)
    );

endmodule

// File: test/tb_ready_queue_sjf_hrrn_picker.sv
// self-checking testbench of the ready queue picker in both scheduling policies
`timescale 1ns / 1ps

module tb_ready_queue_sjf_hrrn_picker;
    import rqp_pkg::*;

    localparam int unsigned DEPTH            = 16;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned STUCK_LIMIT      = 4000;
    localparam int unsigned PHASE_ITEMS      = 225;
    localparam int unsigned PHASE_COUNT      = 6;
    localparam int unsigned CHUNK_ITEMS      = 25;
    localparam int unsigned TAIL_CYCLES      = 80;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
    } t_pick_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // task_id[15:0], burst_estimate[31:16], now_time[63:32]
    logic [0:0]  s_axis_tuser  = '0;    // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // chosen_id[15:0]
    logic [1:0]  m_axis_tuser;          // status[1:0]

    // predicted ready table
    logic                rt_live    [DEPTH] = '{default: 1'b0};
    logic [ID_W-1:0]     rt_task    [DEPTH];
    logic [EST_W-1:0]    rt_est     [DEPTH];
    logic [TIME_W-1:0]   rt_arrival [DEPTH];
    logic [ORDER_W-1:0]  rt_order   [DEPTH];
    logic [ORDER_W-1:0]  rt_seq    = '0;
    logic                rt_policy = POLICY_SJF;

    t_pick_result pending_picks [$];

    int unsigned      mismatches   = 0;
    int unsigned      idle_cycles  = 0;
    int unsigned      idle_pct     = 0;
    bit               quiet        = 1'b0;
    int unsigned      hold_asks    = 0;
    int unsigned      holds_served = 0;
    int unsigned      sink_stall   = 0;
    logic [TIME_W-1:0] clock_now   = '0;

    ready_queue_sjf_hrrn_picker #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // wait of a slot, saturating at zero when it arrived after now
    function automatic logic [63:0] wait_since(int k, logic [TIME_W-1:0] now);
        return (now < rt_arrival[k]) ? 64'd0 : {32'd0, now - rt_arrival[k]};
    endfunction

    // true when slot a wins over slot b under the current policy
    function automatic bit prefers(int a, int b, logic [TIME_W-1:0] now);
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [ORDER_W-1:0] age_a;
        logic [ORDER_W-1:0] age_b;
        lhs   = wait_since(a, now) * {48'd0, rt_est[b]};
        rhs   = wait_since(b, now) * {48'd0, rt_est[a]};
        age_a = rt_seq - rt_order[a];
        age_b = rt_seq - rt_order[b];
        if (rt_policy == POLICY_SJF) begin
            if (rt_est[a] != rt_est[b])
                return rt_est[a] < rt_est[b];
        end else if (lhs != rhs) begin
            return lhs > rhs;
        end
        return age_a > age_b;
    endfunction

    // apply one request to the predicted table and return its result
    function automatic t_pick_result predict_pick(logic kind, logic [ID_W-1:0] id,
            logic [EST_W-1:0] est, logic [TIME_W-1:0] now);
        t_pick_result res;
        int best;
        best   = -1;
        res.id = id;
        if (kind == REQ_INSERT) begin
            for (int k = DEPTH - 1; k >= 0; k--)
                if (!rt_live[k])
                    best = k;
            if (best < 0) begin
                res.status = ST_FULL;
            end else begin
                rt_live[best]    = 1'b1;
                rt_task[best]    = id;
                rt_est[best]     = (est == '0) ? EST_W'(1) : est;
                rt_arrival[best] = now;
                rt_order[best]   = rt_seq;
                rt_seq           = rt_seq + 1'b1;
                res.status       = ST_INSERTED;
            end
        end else begin
            for (int k = 0; k < DEPTH; k++)
                if (rt_live[k] && (best < 0 || prefers(k, best, now)))
                    best = k;
            if (best < 0) begin
                res.id     = '0;
                res.status = ST_EMPTY;
            end else begin
                rt_live[best] = 1'b0;
                res.id        = rt_task[best];
                res.status    = ST_DISPATCHED;
            end
        end
        return res;
    endfunction

    // offer one request, optionally after a gap, and log its expected result on transfer
    task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
            input logic [EST_W-1:0] est, input logic [TIME_W-1:0] now);
        if (!quiet && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, est, id};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_picks.push_back(predict_pick(kind, id, est, now));
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // policy register write, only while the block is idle
    task automatic write_policy(input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        rt_policy = mode;
        i_cfg_we  <= 1'b0;
    endtask

    // one random request with a drifting clock, rare jumps and rare earlier times
    task automatic random_request(input int unsigned insert_pct);
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [EST_W-1:0]  est;
        logic [TIME_W-1:0] now;
        int unsigned       pick;
        kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_DISPATCH;
        id   = ID_W'($urandom);
        pick = $urandom_range(9);
        if (pick < 4)
            est = EST_W'($urandom_range(4));
        else if (pick < 8)
            est = EST_W'($urandom_range(300));
        else
            est = EST_W'($urandom);
        pick = $urandom_range(19);
        if (pick == 0)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(40);
        now = (pick == 1) ? clock_now - $urandom_range(200) : clock_now;
        send_request(kind, id, est, now);
    endtask

    // empty dispatch, field extremes, fill to full, full insert, estimate ties
    task automatic test_table_edges();
        logic [ID_W-1:0] ids [DEPTH] = '{
            16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0001, 16'h8000, 16'h7FFF, 16'h1234,
            16'hFEDC, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h2468};
        logic [EST_W-1:0] ests [DEPTH] = '{
            16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd7, 16'd7, 16'h8000, 16'd2,
            16'h7FFF, 16'd3, 16'd1, 16'd9, 16'hFFFE, 16'd4, 16'd5, 16'd6};
        logic [TIME_W-1:0] times [DEPTH] = '{
            32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 32'd100, 32'd5,
            32'h5555_5555, 32'hAAAA_AAAA, 32'd1, 32'd200, 32'd300, 32'd0, 32'd50,
            32'hFFFF_0000, 32'd60};
        write_policy(POLICY_SJF);
        quiet    = 1'b0;
        idle_pct = 25;
        send_request(REQ_DISPATCH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < DEPTH; k++)
            send_request(REQ_INSERT, ids[k], ests[k], times[k]);
        send_request(REQ_INSERT, 16'hBEEF, 16'd0, 32'd0);
        send_request(REQ_DISPATCH, 16'd0, 16'd0, 32'd0);
        send_request(REQ_DISPATCH, 16'd0, 16'd0, 32'd0);
        settle();
    endtask

    // response ratio with all waits saturated, maximal waits and mixed waits
    task automatic test_ratio_edges();
        write_policy(POLICY_HRRN);
        send_request(REQ_DISPATCH, 16'hAAAA, 16'h5555, 32'd0);
        send_request(REQ_DISPATCH, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF);
        send_request(REQ_DISPATCH, 16'd0, 16'd0, 32'h8000_0000);
        send_request(REQ_DISPATCH, 16'd0, 16'd0, 32'd150);
        settle();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        idle_pct  = 0;
        hold_asks = hold_asks + 1;
        for (int n = 0; n < 12; n++)
            random_request(60);
        settle();
    endtask

    // random mix with the fill level and idling changing every chunk
    task automatic test_random_mix(input logic policy, input bit last_phase);
        int unsigned insert_pct;
        insert_pct = 50;
        write_policy(policy);
        quiet = last_phase;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % CHUNK_ITEMS == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 25;
                    default: idle_pct = 60;
                endcase
            end
            random_request(insert_pct);
        end
        settle();
    endtask

    // receiver: long hold on request, else random stall bursts
    always @(posedge i_clk) begin
        if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            sink_stall   = LONG_HOLD_CYCLES;
        end else if (sink_stall == 0 && !quiet && $urandom_range(399) < idle_pct) begin
            sink_stall = $urandom_range(7, 1);
        end
        if (sink_stall > 0) begin
            sink_stall    = sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expected pick
    always @(posedge i_clk) begin : check_results
        t_pick_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_picks.size() == 0) begin
                $error("unexpected result transfer: chosen_id %0h status %0d",
                       m_axis_tdata, m_axis_tuser);
                mismatches = mismatches + 1;
            end else begin
                want = pending_picks.pop_front();
                if (m_axis_tdata !== want.id) begin
                    $error("chosen_id: expected %0h, got %0h", want.id, m_axis_tdata);
                    mismatches = mismatches + 1;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STUCK_LIMIT) begin
            $display("tb_ready_queue_sjf_hrrn_picker: FAIL");
            $finish;
        end
    end

    // reset, tests in turn, drain and verdict
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_edges();
        test_ratio_edges();
        test_output_backpressure();
        for (int p = 0; p < PHASE_COUNT; p++)
            test_random_mix(p[0], p == PHASE_COUNT - 1);
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_picks.size() == 0)
            $display("tb_ready_queue_sjf_hrrn_picker: PASS");
        else
            $display("tb_ready_queue_sjf_hrrn_picker: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/rqp_pkg.sv
rtl/rqp_ram.sv
rtl/rqp_ctrl.sv
rtl/rqp_datapath.sv
rtl/ready_queue_sjf_hrrn_picker.sv
test/tb_ready_queue_sjf_hrrn_picker.sv
